// ===== design/mmnp_pkg.sv =====
// Package for the min-max normalize to pixel core.
// Shared widths, register map, queue entry type and back-end state codes.
// No dependencies.
package mmnp_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int SCALE_BITS  = 16;
  localparam int PIXEL_BITS  = 8;
  localparam int DIFF_BITS   = SAMPLE_BITS + 1;
  localparam int PROD_BITS   = DIFF_BITS + SCALE_BITS;
  localparam int CNT_BITS    = $clog2(PIXEL_BITS + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(255);

  localparam logic REG_OUTPUT_SCALE = 1'b0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SCALE_BITS-1:0]         scale_t;
  typedef logic [PIXEL_BITS-1:0]         pixel_t;
  typedef logic [DIFF_BITS-1:0]          diff_t;
  typedef logic [PROD_BITS-1:0]          prod_t;

  typedef struct packed {
    logic  zero;
    diff_t diff;
    diff_t span;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } back_state_t;

endpackage

// ===== design/min_max_normalize_to_pixel_core.sv =====
// Top level of the min-max normalize to pixel core.
// Instantiates mmnp_front, mmnp_queue and mmnp_back; holds the APB register.
// Depends on mmnp_pkg.
//
//   channel   handshake            fields
//   input     push / full          op, sample, first
//   result    pop / empty          pixel
//   config    psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// A measure word is taken by the front end and yields no result.
// A scale word passes the back end in order: take, multiply, 9 divide
// steps (saturation check plus 8 quotient bits), deliver; the divider sets the rate.
// Zero-result words skip to deliver; saturated words stop after one step.
// The two-entry queue lets measure and scale words enter while the divider works.
// Reset is synchronous: marks to 0, output_scale to 255, queue and output empty.
// A held result stalls the back end only when the next pixel is ready to deliver.
module min_max_normalize_to_pixel_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  op,
  input  mmnp_pkg::sample_t                     sample,
  input  logic                                  first,
  output logic                                  empty,
  input  logic                                  pop,
  output mmnp_pkg::pixel_t                      pixel,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mmnp_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [mmnp_pkg::APB_DATA_BITS-1:0]    pwdata,
  output logic [mmnp_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);
  import mmnp_pkg::*;

  scale_t output_scale;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t wr_entry;
  entry_t rd_entry;
  logic   reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_BITS-1] == REG_OUTPUT_SCALE);
  assign prdata  = reg_hit ? APB_DATA_BITS'(output_scale) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_scale <= SCALE_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      output_scale <= pwdata[SCALE_BITS-1:0];
    end
  end

  mmnp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .op      (op),
    .sample  (sample),
    .first   (first),
    .scale   (output_scale),
    .q_full  (full),
    .q_push  (q_push),
    .q_entry (wr_entry)
  );

  mmnp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_entry (wr_entry),
    .rd_en    (q_pop),
    .full     (full),
    .valid    (q_valid),
    .rd_entry (rd_entry)
  );

  mmnp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (rd_entry),
    .scale   (output_scale),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .pixel   (pixel)
  );

endmodule

// ===== design/mmnp_front.sv =====
// Front end: accepts words, tracks the column minimum and maximum,
// and turns scale words into queue entries. Depends on mmnp_pkg.
module mmnp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               op,
  input  mmnp_pkg::sample_t  sample,
  input  logic               first,
  input  mmnp_pkg::scale_t   scale,
  input  logic               q_full,
  output logic               q_push,
  output mmnp_pkg::entry_t   q_entry
);
  import mmnp_pkg::*;

  sample_t low_mark;
  sample_t high_mark;
  logic    accept;

  assign accept = push && !q_full;
  assign q_push = accept && op;

  always_comb begin
    q_entry.zero = (high_mark <= low_mark) || (scale == '0) || (sample <= low_mark);
    q_entry.diff = {sample[SAMPLE_BITS-1], sample} - {low_mark[SAMPLE_BITS-1], low_mark};
    q_entry.span = {high_mark[SAMPLE_BITS-1], high_mark} - {low_mark[SAMPLE_BITS-1], low_mark};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_mark  <= '0;
      high_mark <= '0;
    end else if (accept && !op) begin
      if (first) begin
        low_mark  <= sample;
        high_mark <= sample;
      end else begin
        if (sample < low_mark) low_mark <= sample;
        if (sample > high_mark) high_mark <= sample;
      end
    end
  end

endmodule

// ===== design/mmnp_queue.sv =====
// Short queue between front and back end.
// Holds scale entries in order. Depends on mmnp_pkg.
module mmnp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mmnp_pkg::entry_t  wr_entry,
  input  logic              rd_en,
  output logic              full,
  output logic              valid,
  output mmnp_pkg::entry_t  rd_entry
);
  import mmnp_pkg::*;

  entry_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   count;
  logic                   do_wr;
  logic                   do_rd;

  assign full     = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign valid    = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && valid;

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_BITS'(do_wr) - QCNT_BITS'(do_rd);
    end
  end

endmodule

// ===== design/mmnp_back.sv =====
// Back end: multiplies, runs a restoring divide one bit per cycle with a
// saturation step, and holds the pixel in an output register. Depends on mmnp_pkg.
module mmnp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  mmnp_pkg::entry_t  q_entry,
  input  mmnp_pkg::scale_t  scale,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output mmnp_pkg::pixel_t  pixel
);
  import mmnp_pkg::*;

  back_state_t          state;
  diff_t                diff;
  prod_t                rem;
  prod_t                dvs;
  pixel_t               quot;
  logic [CNT_BITS-1:0]  cnt;
  logic                 out_valid;
  logic                 room;
  logic                 ge;
  logic                 deliver;

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign room    = !out_valid || pop;
  assign empty   = !out_valid;
  assign ge      = (rem >= dvs);
  assign deliver = (state == ST_DONE) && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= deliver || (out_valid && !pop);
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            quot <= '0;
            if (q_entry.zero) begin
              state <= ST_DONE;
            end else begin
              diff  <= q_entry.diff;
              dvs   <= PROD_BITS'(q_entry.span) << PIXEL_BITS;
              state <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          rem   <= PROD_BITS'(diff) * PROD_BITS'(scale);
          cnt   <= CNT_BITS'(PIXEL_BITS);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == CNT_BITS'(PIXEL_BITS)) begin
            if (ge) begin
              quot  <= '1;
              state <= ST_DONE;
            end else begin
              dvs <= dvs >> 1;
              cnt <= cnt - 1'b1;
            end
          end else begin
            if (ge) rem <= rem - dvs;
            quot <= {quot[PIXEL_BITS-2:0], ge};
            dvs  <= dvs >> 1;
            if (cnt == '0) begin
              state <= ST_DONE;
            end else begin
              cnt <= cnt - 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (room) begin
            pixel <= quot;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/mmnp_checker.sv =====
// Port-level checker for the min-max normalize to pixel core, with its bind.
// Depends on mmnp_pkg.
module mmnp_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  full,
  input  logic                                  empty,
  input  logic                                  pop,
  input  mmnp_pkg::pixel_t                      pixel,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mmnp_pkg::APB_ADDR_BITS-1:0]    paddr,
  input  logic [mmnp_pkg::APB_DATA_BITS-1:0]    pwdata,
  input  logic [mmnp_pkg::APB_DATA_BITS-1:0]    prdata
);
  import mmnp_pkg::*;

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue state not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(pixel))
    else $error("waiting result changed");

  a_reg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[APB_ADDR_BITS-1] == REG_OUTPUT_SCALE)
    |=> (paddr[APB_ADDR_BITS-1] != REG_OUTPUT_SCALE) ||
        (prdata[SCALE_BITS-1:0] == $past(pwdata[SCALE_BITS-1:0])))
    else $error("output_scale readback mismatch");

  a_reg_upper_zero: assert property (@(posedge clk) disable iff (rst)
    prdata[APB_DATA_BITS-1:SCALE_BITS] == '0)
    else $error("unused register bits set");

endmodule

bind min_max_normalize_to_pixel_core mmnp_checker u_mmnp_checker (
  .clk     (clk),
  .rst     (rst),
  .full    (full),
  .empty   (empty),
  .pop     (pop),
  .pixel   (pixel),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);
